FILE: rtl/sorted_unique_id_set_macros.svh
// Assertion macros for the sorted unique id set.
`ifndef SORTED_UNIQUE_ID_SET_MACROS_SVH
`define SORTED_UNIQUE_ID_SET_MACROS_SVH

// Check that cons holds in the same cycle as ant.
`define SUIS_ASSERT_NOW(label, clk, rst, ant, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ant.
`define SUIS_ASSERT_NEXT(label, clk, rst, ant, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/suis_pkg.sv
// Shared constants, types and helpers of the sorted unique id set.
`default_nettype none

package suis_pkg;

   localparam int CAPACITY = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ID_W     = 32;
   localparam int COUNT_FIELD_W = 6;

   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_ZERO = CNT_W'(0);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_FULL      = 2'd2,
      ST_READ_DATA = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SEARCH,
      SEQ_SHIFT,
      SEQ_PLACE,
      SEQ_DONE,
      SEQ_RD_WAIT,
      SEQ_RD_SHOW
   } seq_state_type;

   typedef struct packed {
      status_type                 status;
      logic [ID_W-1:0]            entry;
      logic                       is_empty;
      logic [COUNT_FIELD_W-1:0]   entry_count;
      logic                       last;
   } rsp_word_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [ID_W-1:0]   wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   // Reduce a count to the width of the result field.
   function automatic logic [COUNT_FIELD_W-1:0] count_field(input logic [CNT_W-1:0] c);
      logic [CNT_W+COUNT_FIELD_W-1:0] wide;
      wide = {{COUNT_FIELD_W{1'b0}}, c};
      return wide[COUNT_FIELD_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/suis_ifs.sv
// Request and response channel interfaces of the sorted unique id set.
`default_nettype none

interface suis_req_if;
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [suis_pkg::ID_W-1:0] id_value;

   modport source (output valid, output operation, output id_value, input ready);
   modport sink   (input valid, input operation, input id_value, output ready);
endinterface

interface suis_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         status;
   logic [suis_pkg::ID_W-1:0]          entry;
   logic                               is_empty;
   logic [suis_pkg::COUNT_FIELD_W-1:0] entry_count;
   logic                               last;

   modport source (output valid, output status, output entry, output is_empty,
                   output entry_count, output last, input ready);
   modport sink   (input valid, input status, input entry, input is_empty,
                   input entry_count, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/suis_slot_mem.sv
// Id slot memory: one write port, one read port with registered data.
`default_nettype none

module suis_slot_mem (
   input  wire logic                      clock,
   input  wire suis_pkg::mem_req_type     mem_req,
   output      logic [suis_pkg::ID_W-1:0] rdata
);

   logic [suis_pkg::ID_W-1:0] slot_mem [suis_pkg::CAPACITY];
   logic [suis_pkg::ID_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         slot_mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // Hold read data until the next read.
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rdata_ff <= slot_mem[mem_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/suis_seq.sv
// Sequencer: search, shift, place and read-out passes over the slot memory.
`default_nettype none

module suis_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic                          req_operation,
   input  wire logic [suis_pkg::ID_W-1:0]     req_id_value,
   output      logic                          res_valid,
   input  wire logic                          res_ready,
   output      suis_pkg::rsp_word_type        res_word,
   output      suis_pkg::mem_req_type         mem_req,
   input  wire logic [suis_pkg::ID_W-1:0]     rdata,
   output      logic [suis_pkg::CNT_W-1:0]    stored_count
);

   suis_pkg::seq_state_type state_ff, state_in;
   logic [suis_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [suis_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [suis_pkg::CNT_W-1:0]  pos_ff, pos_in;
   logic [suis_pkg::ID_W-1:0]   id_ff, id_in;
   suis_pkg::rsp_word_type      res_ff, res_in;

   logic                        accept;
   logic [suis_pkg::CNT_W-1:0]  idx_inc;
   logic [suis_pkg::CNT_W-1:0]  idx_dec;
   logic [suis_pkg::CNT_W-1:0]  cnt_dec;
   logic                        at_end;
   logic                        hit_eq;
   logic                        hit_gt;
   logic                        is_full;
   logic                        cnt_zero;

   assign accept   = req_valid && req_ready;
   assign idx_inc  = idx_ff + suis_pkg::CNT_ONE;
   assign idx_dec  = idx_ff - suis_pkg::CNT_ONE;
   assign cnt_dec  = cnt_ff - suis_pkg::CNT_ONE;
   assign at_end   = (idx_inc == cnt_ff);
   assign hit_eq   = (rdata == id_ff);
   assign hit_gt   = (rdata > id_ff);
   assign is_full  = (cnt_ff == suis_pkg::CAP_CNT);
   assign cnt_zero = (cnt_ff == suis_pkg::CNT_ZERO);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         suis_pkg::SEQ_IDLE: begin
            if (accept) begin
               if (req_operation == suis_pkg::OP_READ) begin
                  state_in = cnt_zero ? suis_pkg::SEQ_DONE : suis_pkg::SEQ_RD_WAIT;
               end else begin
                  state_in = cnt_zero ? suis_pkg::SEQ_PLACE : suis_pkg::SEQ_SEARCH;
               end
            end
         end
         suis_pkg::SEQ_SEARCH: begin
            if (hit_eq) begin
               state_in = suis_pkg::SEQ_DONE;
            end else if (hit_gt || at_end) begin
               if (is_full) begin
                  state_in = suis_pkg::SEQ_DONE;
               end else if (hit_gt) begin
                  state_in = suis_pkg::SEQ_SHIFT;
               end else begin
                  state_in = suis_pkg::SEQ_PLACE;
               end
            end
         end
         suis_pkg::SEQ_SHIFT: begin
            if (idx_ff == pos_ff) begin
               state_in = suis_pkg::SEQ_PLACE;
            end
         end
         suis_pkg::SEQ_PLACE: begin
            state_in = suis_pkg::SEQ_DONE;
         end
         suis_pkg::SEQ_DONE: begin
            if (res_ready) begin
               state_in = suis_pkg::SEQ_IDLE;
            end
         end
         suis_pkg::SEQ_RD_WAIT: begin
            state_in = suis_pkg::SEQ_RD_SHOW;
         end
         suis_pkg::SEQ_RD_SHOW: begin
            if (res_ready && at_end) begin
               state_in = suis_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = suis_pkg::SEQ_IDLE;
         end
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      res_word      = res_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = idx_inc[suis_pkg::ADDR_W-1:0];
      mem_req.wdata = rdata;
      mem_req.re    = 1'b0;
      mem_req.raddr = idx_ff[suis_pkg::ADDR_W-1:0];
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      id_in         = id_ff;
      res_in        = res_ff;
      case (state_ff)
         suis_pkg::SEQ_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               id_in  = req_id_value;
               idx_in = suis_pkg::CNT_ZERO;
               pos_in = suis_pkg::CNT_ZERO;
               if (cnt_zero) begin
                  // Empty read answers at once.
                  res_in.status      = suis_pkg::ST_READ_DATA;
                  res_in.entry       = '0;
                  res_in.is_empty    = 1'b1;
                  res_in.entry_count = '0;
                  res_in.last        = 1'b1;
               end else begin
                  mem_req.re    = 1'b1;
                  mem_req.raddr = '0;
               end
            end
         end
         suis_pkg::SEQ_SEARCH: begin
            res_in.entry       = id_ff;
            res_in.is_empty    = 1'b0;
            res_in.entry_count = suis_pkg::count_field(cnt_ff);
            res_in.last        = 1'b1;
            res_in.status      = hit_eq ? suis_pkg::ST_DUPLICATE : suis_pkg::ST_FULL;
            if (!hit_eq && (hit_gt || at_end)) begin
               pos_in = hit_gt ? idx_ff : idx_inc;
               if (!is_full && hit_gt) begin
                  // Start the shift from the top entry.
                  mem_req.re    = 1'b1;
                  mem_req.raddr = cnt_dec[suis_pkg::ADDR_W-1:0];
                  idx_in        = cnt_dec;
               end
            end else if (!hit_eq) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = idx_inc[suis_pkg::ADDR_W-1:0];
               idx_in        = idx_inc;
            end
         end
         suis_pkg::SEQ_SHIFT: begin
            // Move slot idx up by one while fetching the one below.
            mem_req.we = 1'b1;
            if (idx_ff != pos_ff) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = idx_dec[suis_pkg::ADDR_W-1:0];
               idx_in        = idx_dec;
            end
         end
         suis_pkg::SEQ_PLACE: begin
            mem_req.we         = 1'b1;
            mem_req.waddr      = pos_ff[suis_pkg::ADDR_W-1:0];
            mem_req.wdata      = id_ff;
            cnt_in             = cnt_ff + suis_pkg::CNT_ONE;
            res_in.status      = suis_pkg::ST_INSERTED;
            res_in.entry       = id_ff;
            res_in.is_empty    = 1'b0;
            res_in.entry_count = suis_pkg::count_field(cnt_ff + suis_pkg::CNT_ONE);
            res_in.last        = 1'b1;
         end
         suis_pkg::SEQ_DONE: begin
            res_valid = 1'b1;
         end
         suis_pkg::SEQ_RD_WAIT: begin
            res_valid = 1'b0;
         end
         suis_pkg::SEQ_RD_SHOW: begin
            res_valid            = 1'b1;
            res_word.status      = suis_pkg::ST_READ_DATA;
            res_word.entry       = rdata;
            res_word.is_empty    = 1'b0;
            res_word.entry_count = suis_pkg::count_field(cnt_ff);
            res_word.last        = at_end;
            if (res_ready && !at_end) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = idx_inc[suis_pkg::ADDR_W-1:0];
               idx_in        = idx_inc;
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= suis_pkg::SEQ_IDLE;
         cnt_ff   <= suis_pkg::CNT_ZERO;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      id_ff  <= id_in;
      res_ff <= res_in;
   end

   assign stored_count = cnt_ff;

endmodule

`default_nettype wire

FILE: rtl/sorted_unique_id_set.sv
// Top level of the sorted unique id set: sequencer, slot memory, response register.
// Keeps up to CAPACITY (32) distinct 32-bit ids in ascending order in a single
// synchronous slot memory. An insert word first scans the slots from the bottom,
// one slot a cycle, until it meets an id that is equal or larger or the last
// one; an equal id answers "already present", a full set answers "full and
// dropped", and otherwise the larger ids move up one slot a cycle from the top
// down before the new id is written. The scan and the shift are bound by the one
// read and one write port of the slot memory. A read word streams the stored ids
// in order, one response word per cycle while the response register can take it,
// with last marking the final id; an empty set gives one word with is_empty set.
// A new request is taken only once every response word of the previous one has
// been handed to the response register, which lets the last word wait for the
// consumer while the next request is accepted. No clearing pass runs after reset:
// only slots below the stored count are ever read.
`default_nettype none

`include "sorted_unique_id_set_macros.svh"

module sorted_unique_id_set (
   input wire logic  clock,
   input wire logic  reset,
   suis_req_if.sink  req_port,
   suis_rsp_if.source rsp_port
);

   logic                           res_valid;
   logic                           res_ready;
   suis_pkg::rsp_word_type         res_word;
   suis_pkg::mem_req_type          mem_req;
   logic [suis_pkg::ID_W-1:0]      rdata;
   logic [suis_pkg::CNT_W-1:0]     stored_count;

   logic                           rsp_valid_ff, rsp_valid_in;
   suis_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;
   logic                           load;

   suis_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_port.valid),
      .req_ready     (req_port.ready),
      .req_operation (req_port.operation),
      .req_id_value  (req_port.id_value),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res_word      (res_word),
      .mem_req       (mem_req),
      .rdata         (rdata),
      .stored_count  (stored_count)
   );

   suis_slot_mem u_slot_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

   // Response register: take a new word when empty or when the current one leaves.
   assign res_ready = !rsp_valid_ff || rsp_port.ready;
   assign load      = res_valid && res_ready;

   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (load) begin
         rsp_word_in  = res_word;
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         // Drop the word the consumer just took.
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.status      = rsp_word_ff.status;
   assign rsp_port.entry       = rsp_word_ff.entry;
   assign rsp_port.is_empty    = rsp_word_ff.is_empty;
   assign rsp_port.entry_count = rsp_word_ff.entry_count;
   assign rsp_port.last        = rsp_word_ff.last;

   // The stored count never passes the capacity.
   `SUIS_ASSERT_NOW(a_cnt_cap, clock, reset, 1'b1, stored_count <= suis_pkg::CAP_CNT, "count above capacity")

   // The stored count only holds or grows by one.
   `SUIS_ASSERT_NEXT(a_cnt_step, clock, reset, 1'b1, (stored_count == $past(stored_count)) || (stored_count == $past(stored_count) + suis_pkg::CNT_ONE), "count jumped")

   // No response word is pending from the sequencer while it takes a request.
   `SUIS_ASSERT_NOW(a_idle_quiet, clock, reset, req_port.ready, !res_valid, "request taken with response pending")

   // The slot memory never reads and writes the same slot in one cycle.
   `SUIS_ASSERT_NOW(a_mem_rw, clock, reset, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr, "slot read and written together")

endmodule

`default_nettype wire

FILE: test/id_set_check_pkg.sv
// Shadow copy of the id set and the queue of response words it is waiting for.
package id_set_check_pkg;
   import suis_pkg::*;

   class id_set_mirror;
      logic [ID_W-1:0] stored_ids[$];
      rsp_word_type    awaited_words[$];
      int              mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Print one line per mismatch and count it.
      task flag_mismatch(string what);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      function int fill();
         return stored_ids.size();
      endfunction

      function logic [ID_W-1:0] any_stored();
         return stored_ids[$urandom_range(0, stored_ids.size() - 1)];
      endfunction

      // Update the shadow set and queue the words one accepted request causes.
      function void note_request(logic op, logic [ID_W-1:0] id);
         rsp_word_type w;
         int           pos;
         int           n;
         w = '0;
         n = stored_ids.size();
         if (op == OP_INSERT) begin
            pos = 0;
            while (pos < n && stored_ids[pos] < id) pos++;
            w.entry = id;
            w.last  = 1'b1;
            if (pos < n && stored_ids[pos] == id) begin
               w.status = ST_DUPLICATE;
            end else if (n >= CAPACITY) begin
               w.status = ST_FULL;
            end else begin
               stored_ids.insert(pos, id);
               w.status = ST_INSERTED;
            end
            w.entry_count = COUNT_FIELD_W'(stored_ids.size());
            awaited_words.push_back(w);
         end else if (n == 0) begin
            w.status   = ST_READ_DATA;
            w.is_empty = 1'b1;
            w.last     = 1'b1;
            awaited_words.push_back(w);
         end else begin
            for (int i = 0; i < n; i++) begin
               w.status      = ST_READ_DATA;
               w.entry       = stored_ids[i];
               w.entry_count = COUNT_FIELD_W'(n);
               w.last        = (i == n - 1);
               awaited_words.push_back(w);
            end
         end
      endfunction

      // Compare a delivered word with the oldest awaited one, field by field.
      task check_word(rsp_word_type got);
         rsp_word_type want;
         if (awaited_words.size() == 0) begin
            flag_mismatch($sformatf("unexpected word status %0d entry %h",
                                    got.status, got.entry));
            return;
         end
         want = awaited_words.pop_front();
         if (got.status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d (entry %h)",
                                    got.status, want.status, want.entry));
         if (got.entry !== want.entry)
            flag_mismatch($sformatf("entry %h, want %h", got.entry, want.entry));
         if (got.is_empty !== want.is_empty)
            flag_mismatch($sformatf("is_empty %b, want %b", got.is_empty, want.is_empty));
         if (got.entry_count !== want.entry_count)
            flag_mismatch($sformatf("entry_count %0d, want %0d (entry %h)",
                                    got.entry_count, want.entry_count, want.entry));
         if (got.last !== want.last)
            flag_mismatch($sformatf("last %b, want %b (entry %h)",
                                    got.last, want.last, want.entry));
      endtask
   endclass

endpackage

FILE: test/tb_sorted_unique_id_set.sv
// Testbench top of the sorted unique id set: drives requests, takes responses, checks them.
module tb_sorted_unique_id_set;
   timeunit 1ns;
   timeprecision 1ps;

   import suis_pkg::*;
   import id_set_check_pkg::*;

   logic clock;
   logic reset;

   suis_req_if req_bus ();
   suis_rsp_if rsp_bus ();

   sorted_unique_id_set dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   id_set_mirror mirror = new();

   // Idle rates of both sides, re-drawn now and then so that calm stretches and
   // busy stretches alternate; steady turns all idling off near the end.
   int send_idle_pct = 0;
   int take_idle_pct = 0;
   bit steady        = 1'b0;
   // Ask the response side for one long hold-off so the block backs up.
   bit hold_wanted   = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #2ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // Offer one request word, hold it until taken, then note it.
   task automatic send_word(input logic op, input logic [ID_W-1:0] id);
      int gap;
      if (!steady && $urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 13);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.id_value  <= id;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      mirror.note_request(op, id);
   endtask

   // Stimulus: directed words first, then a long random mix.
   initial begin : stimulus
      int              k;
      int              pick;
      int              n_random;
      logic [ID_W-1:0] base;
      n_random = 414;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_INSERT;
      req_bus.id_value  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Read an empty set, then hit both ends of the id range and duplicates.
      send_word(OP_READ,   32'h1234_5678);
      send_word(OP_INSERT, 32'h8000_0000);
      send_word(OP_INSERT, 32'h0000_0000);
      send_word(OP_INSERT, 32'hFFFF_FFFF);
      send_word(OP_INSERT, 32'h0000_0000);
      send_word(OP_INSERT, 32'hFFFF_FFFF);
      send_word(OP_READ,   32'hFFFF_FFFF);
      // Land new ids in the middle so the upper ids shift.
      send_word(OP_INSERT, 32'h7FFF_FFFF);
      send_word(OP_INSERT, 32'h8000_0001);
      send_word(OP_INSERT, 32'h0000_0001);
      send_word(OP_INSERT, 32'hFFFF_FFFE);
      send_word(OP_INSERT, 32'h5555_5555);
      send_word(OP_INSERT, 32'hAAAA_AAAA);
      send_word(OP_INSERT, 32'hAAAA_AAAA);
      send_word(OP_READ,   32'h0000_0000);
      send_word(OP_INSERT, 32'h8000_0000);

      // Random mix: many duplicates and near neighbors of stored ids, so the set
      // fills gradually and then keeps answering full and duplicate.
      for (k = 0; k < n_random; k++) begin
         if (k % 32 == 0) send_idle_pct = $urandom_range(0, 30);
         if (k == 150) hold_wanted = 1'b1;
         if (k == n_random - 50) steady = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            send_word(OP_READ, $urandom());
         end else if (pick < 55 && mirror.fill() > 0) begin
            send_word(OP_INSERT, mirror.any_stored());
         end else if (pick < 68 && mirror.fill() > 0) begin
            base = mirror.any_stored();
            send_word(OP_INSERT, $urandom_range(0, 1) ? base + 32'd1 : base - 32'd1);
         end else if (pick < 80) begin
            send_word(OP_INSERT, $urandom_range(0, 15));
         end else begin
            send_word(OP_INSERT, $urandom());
         end
      end
      req_bus.valid <= 1'b0;

      // Drain, then watch a little longer for stray words.
      while (mirror.awaited_words.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (mirror.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Response side: drop ready in random bursts, and once hold it low long
   // enough that the block stops taking requests.
   initial begin : response_taker
      int gap;
      int cycles;
      bit held;
      held   = 1'b0;
      cycles = 0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (cycles % 64 == 0) take_idle_pct = $urandom_range(0, 25);
         cycles++;
         if (hold_wanted && !held) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (!steady && $urandom_range(0, 99) < take_idle_pct) begin
            gap = $urandom_range(1, 13);
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Check every word handed over on the response channel.
   always @(posedge clock) begin : response_watch
      rsp_word_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.status      = status_type'(rsp_bus.status);
         got.entry       = rsp_bus.entry;
         got.is_empty    = rsp_bus.is_empty;
         got.entry_count = rsp_bus.entry_count;
         got.last        = rsp_bus.last;
         mirror.check_word(got);
      end
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/suis_pkg.sv
rtl/suis_ifs.sv
rtl/suis_slot_mem.sv
rtl/suis_seq.sv
rtl/sorted_unique_id_set.sv
test/id_set_check_pkg.sv
test/tb_sorted_unique_id_set.sv
